// ===== sv/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants of the quality region splitter.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int DEFAULT_MAX_READ_LEN = 4096;

  localparam int CODE_W     = 8;
  localparam int QUAL_W     = 8;
  localparam int START_W    = 12;
  localparam int LENGTH_W   = 13;
  localparam int FRAG_W     = 13;
  localparam int COUNT_W    = 8;
  localparam int CFG_DATA_W = 13;

  localparam logic [CODE_W-1:0] BASE_CODE_MAX = 8'd3;

  localparam logic [QUAL_W-1:0]   RST_QUALITY_THRESHOLD = 8'd0;
  localparam logic [COUNT_W-1:0]  RST_MAX_REGIONS       = 8'd255;
  localparam logic [LENGTH_W-1:0] RST_MIN_REGION_LEN    = 13'd0;
  localparam logic [CODE_W-1:0]   RST_SPACER_CODE       = 8'd11;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    CFG_QUALITY_THRESHOLD,
    CFG_MAX_REGIONS,
    CFG_MIN_REGION_LEN,
    CFG_SPACER_CODE
  } cfg_index_t;

  typedef struct packed {
    logic                is_summary;
    logic [START_W-1:0]  region_start;
    logic [LENGTH_W-1:0] region_length;
    logic [FRAG_W-1:0]   fragment_index;
    logic [COUNT_W-1:0]  region_count;
    logic                last_of_run;
  } result_t;

  // Results caused by one accepted base: first goes out before second.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// ===== sv/qrs_if.sv =====
// ----------------------------------------------------------------------------
// qrs_in_if / qrs_out_if
// Valid/ready channels for read bases and for region results.
// ----------------------------------------------------------------------------
interface qrs_in_if
  import qrs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] base_code;
  logic [QUAL_W-1:0] quality;
  logic              end_of_read;

  modport source (output valid, output base_code, output quality, output end_of_read,
                  input ready);
  modport sink (input valid, input base_code, input quality, input end_of_read,
                output ready);
endinterface

interface qrs_out_if
  import qrs_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                is_summary;
  logic [START_W-1:0]  region_start;
  logic [LENGTH_W-1:0] region_length;
  logic [FRAG_W-1:0]   fragment_index;
  logic [COUNT_W-1:0]  region_count;
  logic                last_of_run;

  modport source (output valid, output is_summary, output region_start,
                  output region_length, output fragment_index, output region_count,
                  output last_of_run, input ready);
  modport sink (input valid, input is_summary, input region_start,
                input region_length, input fragment_index, input region_count,
                input last_of_run, output ready);
endinterface

// ===== sv/qrs_core.sv =====
// ----------------------------------------------------------------------------
// qrs_core
// Configuration registers and per-read state; classifies each base, closes
// runs and builds the region and summary results of one transfer.
// ----------------------------------------------------------------------------
module qrs_core
  import qrs_pkg::*;
#(
  parameter int MAX_READ_LEN = DEFAULT_MAX_READ_LEN
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  space_ok,
  qrs_in_if.sink                bases,
  output push_t                 push
);

  localparam int POS_W = $clog2(MAX_READ_LEN);
  localparam int LEN_W = $clog2(MAX_READ_LEN + 1);
  localparam int CMP_W = (LEN_W > LENGTH_W) ? LEN_W : LENGTH_W;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_READ_LEN - 1);
  localparam logic [LEN_W-1:0] LEN_WRAP = LEN_W'(MAX_READ_LEN);

  logic [QUAL_W-1:0]   quality_threshold;
  logic [COUNT_W-1:0]  max_regions;
  logic [LENGTH_W-1:0] min_region_len;
  logic [CODE_W-1:0]   spacer_code;

  logic [POS_W-1:0]   position, position_next;
  logic [POS_W-1:0]   run_start, run_start_next;
  logic               in_good_run, in_good_run_next;
  logic [COUNT_W-1:0] regions_emitted, regions_emitted_next;
  logic [FRAG_W-1:0]  spacer_count, spacer_count_next;
  logic [LEN_W-1:0]   longest_run, longest_run_next;
  logic               limit_reached, limit_reached_next;

  logic               accept;
  logic               good;
  logic               limit;
  logic [POS_W-1:0]   start_eff;
  logic [LEN_W-1:0]   diff;
  logic [LEN_W-1:0]   close_len;
  logic               close;
  logic               emit;
  logic [COUNT_W-1:0] regions_inc;
  logic [LEN_W-1:0]   longest_upd;
  logic [COUNT_W-1:0] regions_upd;
  result_t            region_item;
  result_t            summary_item;

  assign bases.ready = space_ok;
  assign accept      = bases.valid & space_ok;

  assign good  = (bases.quality >= quality_threshold) && (bases.base_code <= BASE_CODE_MAX);
  assign limit = limit_reached || (regions_emitted >= max_regions);
  assign start_eff = in_good_run ? run_start : position;

  always_comb begin
    diff = LEN_W'(position) - LEN_W'(start_eff);
    if (position < start_eff) begin
      diff = diff + LEN_WRAP;
    end
  end

  assign close_len   = good ? (diff + LEN_W'(1)) : diff;
  assign close       = !limit && (good ? bases.end_of_read : in_good_run);
  assign emit        = close && (CMP_W'(close_len) >= CMP_W'(min_region_len));
  assign regions_inc = regions_emitted + COUNT_W'(1);
  assign longest_upd = (close && (close_len > longest_run)) ? close_len : longest_run;
  assign regions_upd = emit ? regions_inc : regions_emitted;

  always_comb begin
    region_item                = '0;
    region_item.region_start   = START_W'(start_eff);
    region_item.region_length  = LENGTH_W'(close_len);
    region_item.fragment_index = spacer_count;
    region_item.last_of_run    = !bases.end_of_read;

    summary_item               = '0;
    summary_item.is_summary    = 1'b1;
    summary_item.region_length = LENGTH_W'(longest_upd);
    summary_item.region_count  = regions_upd;
    summary_item.last_of_run   = 1'b1;
  end

  always_comb begin
    position_next        = position;
    run_start_next       = run_start;
    in_good_run_next     = in_good_run;
    regions_emitted_next = regions_emitted;
    spacer_count_next    = spacer_count;
    longest_run_next     = longest_run;
    limit_reached_next   = limit_reached;
    push                 = '0;

    if (accept) begin
      if (limit) begin
        limit_reached_next = 1'b1;
      end else if (good) begin
        in_good_run_next = 1'b1;
        run_start_next   = start_eff;
      end else begin
        in_good_run_next = 1'b0;
        if ((bases.base_code == spacer_code) && (spacer_count != '1)) begin
          spacer_count_next = spacer_count + FRAG_W'(1);
        end
      end

      longest_run_next     = longest_upd;
      regions_emitted_next = regions_upd;
      if (emit && (regions_inc >= max_regions)) begin
        limit_reached_next = 1'b1;
      end

      if (emit) begin
        push.count  = 2'd1;
        push.first  = region_item;
        push.second = summary_item;
      end else begin
        push.first  = summary_item;
      end

      if (bases.end_of_read) begin
        push.count           = emit ? 2'd2 : 2'd1;
        position_next        = '0;
        run_start_next       = '0;
        in_good_run_next     = 1'b0;
        regions_emitted_next = '0;
        spacer_count_next    = '0;
        longest_run_next     = '0;
        limit_reached_next   = 1'b0;
      end else begin
        position_next = (position == POS_LAST) ? '0 : position + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quality_threshold <= RST_QUALITY_THRESHOLD;
      max_regions       <= RST_MAX_REGIONS;
      min_region_len    <= RST_MIN_REGION_LEN;
      spacer_code       <= RST_SPACER_CODE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUALITY_THRESHOLD: quality_threshold <= QUAL_W'(cfg_data);
        CFG_MAX_REGIONS:       max_regions       <= COUNT_W'(cfg_data);
        CFG_MIN_REGION_LEN:    min_region_len    <= LENGTH_W'(cfg_data);
        CFG_SPACER_CODE:       spacer_code       <= CODE_W'(cfg_data);
        default:               quality_threshold <= quality_threshold;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position        <= '0;
      run_start       <= '0;
      in_good_run     <= 1'b0;
      regions_emitted <= '0;
      spacer_count    <= '0;
      longest_run     <= '0;
      limit_reached   <= 1'b0;
    end else begin
      position        <= position_next;
      run_start       <= run_start_next;
      in_good_run     <= in_good_run_next;
      regions_emitted <= regions_emitted_next;
      spacer_count    <= spacer_count_next;
      longest_run     <= longest_run_next;
      limit_reached   <= limit_reached_next;
    end
  end

endmodule

// ===== sv/qrs_out_queue.sv =====
// ----------------------------------------------------------------------------
// qrs_out_queue
// Small result queue: takes up to two results a cycle, hands out one per
// transfer; space_ok while two entries are free.
// ----------------------------------------------------------------------------
module qrs_out_queue
  import qrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  push_t      push,
  output logic       space_ok,
  qrs_out_if.source  results
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    fill;
  logic                pop;
  result_t             head;

  assign pop      = results.valid & results.ready;
  assign space_ok = (fill <= CNT_W'(QUEUE_DEPTH - 2));
  assign head     = entries[rd_ptr];

  assign results.valid          = (fill != '0);
  assign results.is_summary     = head.is_summary;
  assign results.region_start   = head.region_start;
  assign results.region_length  = head.region_length;
  assign results.fragment_index = head.fragment_index;
  assign results.region_count   = head.region_count;
  assign results.last_of_run    = head.last_of_run;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      fill   <= fill + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

endmodule

// ===== sv/quality_region_splitter.sv =====
// ----------------------------------------------------------------------------
// quality_region_splitter
// Splits a read into runs of good bases; emits long runs as regions and an
// end-of-read summary with the region count and longest good run.
// ----------------------------------------------------------------------------
// Results are registered into the result queue with the base transfer.
// Throughput: one base per cycle while the result queue has two free
//   entries; a base causing two results has them handed out in turn.
// Reset: clears read state and result queue, registers take defaults.
module quality_region_splitter
  import qrs_pkg::*;
#(
  parameter int MAX_READ_LEN = DEFAULT_MAX_READ_LEN
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  qrs_in_if.sink                bases,
  qrs_out_if.source             results
);

  push_t push;
  logic  space_ok;

  qrs_core #(
    .MAX_READ_LEN(MAX_READ_LEN)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .space_ok  (space_ok),
    .bases     (bases),
    .push      (push)
  );

  qrs_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .space_ok (space_ok),
    .results  (results)
  );

endmodule
